// ===== rtl/wbps_pkg.sv =====
// Shared constants, types and register codes of the wildcard byte pattern
// search core. No dependencies; every other file of the block uses it.
package wbps_pkg;

  localparam int PatternMax = 32;   // bytes in the search window
  localparam int RegBytes   = 32;   // pattern bytes the registers hold
  localparam int OffsetBits = 32;   // width of byte count and offset
  localparam int LenBits    = 6;    // width of the pattern length register
  localparam int CareBits   = 32;   // width of the care mask register
  localparam int WordBits   = 64;   // width of one pattern word register
  localparam int CfgIdxBits = 3;    // width of the register index

  // Usable pattern length is capped by both the window and the registers
  localparam int LenCap = (PatternMax < RegBytes) ? PatternMax : RegBytes;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_PATTERN_WORD_0 = 3'd0,
    CFG_PATTERN_WORD_1 = 3'd1,
    CFG_PATTERN_WORD_2 = 3'd2,
    CFG_PATTERN_WORD_3 = 3'd3,
    CFG_CARE_MASK      = 3'd4,
    CFG_PATTERN_LENGTH = 3'd5
  } cfg_reg_e;

  typedef logic [PatternMax-1:0][7:0] window_t;

  // Pattern aligned to the window: entry j is compared with window byte j
  typedef struct packed {
    window_t                 pat;
    logic [PatternMax-1:0]   care;
    logic [LenBits-1:0]      len;
  } align_t;

endpackage

// ===== rtl/wbps_intf.sv =====
// Handshake channels of the wildcard byte pattern search core: byte input,
// result output and register write. Depends on wbps_pkg.
interface wbps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_result_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [wbps_pkg::OffsetBits-1:0]   match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

interface wbps_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [wbps_pkg::CfgIdxBits-1:0]   index;
  logic [wbps_pkg::WordBits-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/wildcard_byte_pattern_search_core.sv =====
// Top level of the wildcard byte pattern search: window register, byte
// count, compare stage and result register. Depends on wbps_pkg,
// wbps_intf and wbps_cfg.
//
//   channel   dir  transfer carries             notes
//   byte_i    in   data_byte, last_byte         one byte of the region
//   result_o  out  found, match_offset          at most one per region
//   cfg_i     in   index, data                  always ready
//
// One byte per clock while result_o is not stalled; the byte that causes a
// result passes the window register, then the result register.
// Reset clears the window bookkeeping and register file, and the byte count
// restarts from zero with the next byte; the pattern length resets to one.
// A stalled result holds the compare stage; a byte is still taken while
// the window stage is empty.
module wildcard_byte_pattern_search_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  wbps_byte_if.sink      byte_i,
  wbps_result_if.source  result_o,
  wbps_cfg_if.sink       cfg_i
);

  localparam int OB = wbps_pkg::OffsetBits;
  localparam int PM = wbps_pkg::PatternMax;

  wbps_pkg::align_t align;

  wbps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .align_o (align)
  );

  // ---------------- window stage ----------------
  logic                 s1_valid_q, s1_valid_d;
  wbps_pkg::window_t    win_q, win_base;
  logic [OB-1:0]        cnt_q, cnt_base;
  logic                 last_q;
  logic                 restart_q;   // previous byte closed a region
  logic                 in_xfer;
  logic                 adv;         // compare stage may move

  assign adv          = !result_o.valid || result_o.ready;
  assign byte_i.ready = !s1_valid_q || adv;
  assign in_xfer      = byte_i.valid && byte_i.ready;
  assign s1_valid_d   = in_xfer || (s1_valid_q && !adv);

  // A new region starts from an empty window and a zero count
  assign win_base = restart_q ? '0 : win_q;
  assign cnt_base = restart_q ? '0 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      restart_q  <= 1'b1;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_xfer) begin
        restart_q <= byte_i.last_byte;
      end
    end
  end

  // Shift the newest byte in at index 0; saturate the count
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      win_q  <= {win_base[PM-2:0], byte_i.data_byte};
      cnt_q  <= (&cnt_base) ? cnt_base : cnt_base + OB'(1);
      last_q <= byte_i.last_byte;
    end
  end

  // ---------------- compare stage ----------------
  logic [PM-1:0] byte_ok;
  logic          hit;
  logic          emit;
  logic          reported_q;
  logic          out_valid_q;
  logic          found_q;
  logic [OB-1:0] offset_q;

  always_comb begin
    for (int j = 0; j < PM; j++) begin
      byte_ok[j] = !align.care[j] || (win_q[j] == align.pat[j]);
    end
  end

  assign hit  = (cnt_q >= OB'(align.len)) && (&byte_ok);
  // Ignore the rest of a region once its match went out
  assign emit = !reported_q && (hit || last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      reported_q  <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q && emit;
      if (s1_valid_q) begin
        reported_q <= last_q ? 1'b0 : (reported_q || hit);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      found_q  <= hit;
      offset_q <= hit ? (cnt_q - OB'(align.len)) : '0;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.found        = found_q;
  assign result_o.match_offset = offset_q;

endmodule

// ===== rtl/wbps_cfg.sv =====
// Configuration registers and the registered alignment of the pattern to
// the search window. Depends on wbps_pkg and wbps_intf.
module wbps_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  wbps_cfg_if.sink            cfg_i,
  output wbps_pkg::align_t    align_o
);

  logic [wbps_pkg::WordBits-1:0] word_q [4];
  logic [wbps_pkg::CareBits-1:0] care_q;
  logic [wbps_pkg::LenBits-1:0]  len_q;
  wbps_pkg::align_t              align_d, align_q;

  logic [wbps_pkg::RegBytes-1:0][7:0] pat_bytes;
  logic [wbps_pkg::LenBits-1:0]       elen;
  logic [wbps_pkg::LenBits-1:0]       src;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q[0] <= '0;
      word_q[1] <= '0;
      word_q[2] <= '0;
      word_q[3] <= '0;
      care_q    <= '0;
      len_q     <= wbps_pkg::LenBits'(1);
    end else if (cfg_i.valid) begin
      case (wbps_pkg::cfg_reg_e'(cfg_i.index))
        wbps_pkg::CFG_PATTERN_WORD_0: word_q[0] <= cfg_i.data;
        wbps_pkg::CFG_PATTERN_WORD_1: word_q[1] <= cfg_i.data;
        wbps_pkg::CFG_PATTERN_WORD_2: word_q[2] <= cfg_i.data;
        wbps_pkg::CFG_PATTERN_WORD_3: word_q[3] <= cfg_i.data;
        wbps_pkg::CFG_CARE_MASK:      care_q    <= cfg_i.data[wbps_pkg::CareBits-1:0];
        wbps_pkg::CFG_PATTERN_LENGTH: len_q     <= cfg_i.data[wbps_pkg::LenBits-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign pat_bytes = {word_q[3], word_q[2], word_q[1], word_q[0]};

  // Zero acts as one, too large saturates
  always_comb begin
    if (len_q == '0) begin
      elen = wbps_pkg::LenBits'(1);
    end else if (len_q > wbps_pkg::LenBits'(wbps_pkg::LenCap)) begin
      elen = wbps_pkg::LenBits'(wbps_pkg::LenCap);
    end else begin
      elen = len_q;
    end
  end

  // Pattern byte i meets window byte len-1-i; flip it so entry j faces window byte j
  always_comb begin
    align_d.len = elen;
    src         = '0;
    for (int j = 0; j < wbps_pkg::PatternMax; j++) begin
      src = elen - wbps_pkg::LenBits'(1) - wbps_pkg::LenBits'(j);
      if (wbps_pkg::LenBits'(j) < elen) begin
        align_d.pat[j]  = pat_bytes[src[4:0]];
        align_d.care[j] = care_q[src[4:0]];
      end else begin
        align_d.pat[j]  = 8'h00;
        align_d.care[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q.pat  <= '0;
      align_q.care <= '0;
      align_q.len  <= wbps_pkg::LenBits'(1);
    end else begin
      align_q <= align_d;
    end
  end

  assign align_o = align_q;

endmodule
